/* hdl/gtg_pkg.sv */
// Shared constants, widths and the arctangent table of the go-to-goal controller.
`timescale 1ns / 1ps
package gtg_pkg;

	// Configuration register indexes.
	localparam logic [2:0] REG_GOAL_X      = 3'd0;
	localparam logic [2:0] REG_GOAL_Y      = 3'd1;
	localparam logic [2:0] REG_GOAL_SET    = 3'd2;
	localparam logic [2:0] REG_TOLERANCE   = 3'd3;
	localparam logic [2:0] REG_LINEAR_GAIN = 3'd4;
	localparam logic [2:0] REG_ANGLE_GAIN  = 3'd5;

	// Angles: pi and two pi in Q4.12, a quarter turn in units of 2^-16 rad.
	localparam logic signed [16:0] PI_Q12      = 17'sd12868;
	localparam logic signed [16:0] TWO_PI_Q12  = 17'sd25736;
	localparam logic signed [19:0] HALF_PI_Q16 = 20'sd102944;

	// Pipeline geometry.
	localparam int CORDIC_STEPS = 16;
	localparam int SQRT_STEPS   = 33;
	localparam int CW           = 52;  // CORDIC x and y width
	localparam int ZW           = 20;  // CORDIC angle width
	localparam int RW           = 67;  // square root remainder width

	// Rounded arctangent of 2^-i in units of 2^-16 rad.
	function automatic logic signed [ZW-1:0] atan_q16(input int i);
		logic signed [ZW-1:0] a;
		begin
			unique case (i)
				0: a = 20'sd51472;
				1: a = 20'sd30386;
				2: a = 20'sd16055;
				3: a = 20'sd8150;
				4: a = 20'sd4091;
				5: a = 20'sd2047;
				6: a = 20'sd1024;
				7: a = 20'sd512;
				8: a = 20'sd256;
				9: a = 20'sd128;
				10: a = 20'sd64;
				11: a = 20'sd32;
				12: a = 20'sd16;
				13: a = 20'sd8;
				14: a = 20'sd4;
				15: a = 20'sd2;
				default: a = '0;
			endcase
			return a;
		end
	endfunction

endpackage

/* hdl/go_to_goal_p_controller_top.sv */
// Top level of the pipelined go-to-goal proportional controller.
`timescale 1ns / 1ps
// Usage:
// An odometry request (pos_x, pos_y in Q16.16, heading in Q3.12) is taken at
// each rising edge where start is high and busy is low. busy never rises, so
// one request can enter in every clock cycle.
// While goal_set is clear a request gives no result. Otherwise the result
// (linear_speed, turn_rate, reached) appears once the request has passed the whole
// pipeline up to the output register and is shown for exactly one cycle with strobe high.
// The latency is set by the square root, which resolves one bit of the
// distance per pipeline stage over 33 stages; the CORDIC bearing path is
// shorter and its result is delayed to line up with the distance.
// Configuration is written through cfg_we, cfg_index and cfg_wdata with no
// wait; write only while no request is in flight. Unknown indexes are ignored.
// Reset clears all valid bits and loads the default goal, tolerance and gains.
// The receiver cannot stall the block; every result is taken as it appears.
module go_to_goal_p_controller_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic signed [31:0]  pos_x,
	input  logic signed [31:0]  pos_y,
	input  logic signed [14:0]  heading,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_wdata,
	output logic                strobe,
	output logic [30:0]         linear_speed,
	output logic signed [15:0]  turn_rate,
	output logic                reached
);
	import gtg_pkg::*;

	localparam int LAT = 39;

	// Configuration registers.
	logic signed [31:0] goal_x_q, goal_y_q;
	logic               goal_set_q;
	logic [31:0]        tol_q;
	logic [15:0]        lin_gain_q, ang_gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_x_q   <= '0;
			goal_y_q   <= '0;
			goal_set_q <= 1'b0;
			tol_q      <= 32'd65536;
			lin_gain_q <= 16'd655;
			ang_gain_q <= 16'd6554;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GOAL_X:      goal_x_q   <= cfg_wdata;
				REG_GOAL_Y:      goal_y_q   <= cfg_wdata;
				REG_GOAL_SET:    goal_set_q <= cfg_wdata[0];
				REG_TOLERANCE:   tol_q      <= cfg_wdata;
				REG_LINEAR_GAIN: lin_gain_q <= cfg_wdata[15:0];
				REG_ANGLE_GAIN:  ang_gain_q <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	// Valid bits travel down the pipe; a request without a goal is dropped here.
	logic [LAT:1] vld;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else begin
			vld <= {vld[LAT-1:1], start & ~busy & goal_set_q};
		end
	end

	// Stage 1: offset to the goal.
	logic signed [32:0] dx_s1, dy_s1;
	logic signed [14:0] hd_s1;
	always_ff @(posedge clk) begin
		dx_s1 <= 33'(goal_x_q) - 33'(pos_x);
		dy_s1 <= 33'(goal_y_q) - 33'(pos_y);
		hd_s1 <= heading;
	end

	// Stages 2 to 4: absolute values, squares and their sum.
	logic [31:0] ax_s2, ay_s2;
	logic [63:0] sqx_s3, sqy_s3;
	logic [64:0] sum_s4;
	always_ff @(posedge clk) begin
		ax_s2  <= dx_s1[32] ? 32'(-dx_s1) : dx_s1[31:0];
		ay_s2  <= dy_s1[32] ? 32'(-dy_s1) : dy_s1[31:0];
		sqx_s3 <= ax_s2 * ax_s2;
		sqy_s3 <= ay_s2 * ay_s2;
		sum_s4 <= {1'b0, sqx_s3} + {1'b0, sqy_s3};
	end

	// Stages 5 to 37: restoring square root, one root bit per stage.
	logic [RW-1:0] rem_s  [0:SQRT_STEPS];
	logic [32:0]   root_s [0:SQRT_STEPS];
	assign rem_s[0]  = RW'(sum_s4);
	assign root_s[0] = '0;

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
		localparam int B = SQRT_STEPS - 1 - k;
		logic [RW-1:0] trial;
		assign trial = (RW'(root_s[k]) << (B + 1)) | (RW'(1) << (2 * B));
		always_ff @(posedge clk) begin
			if (rem_s[k] >= trial) begin
				rem_s[k+1]  <= rem_s[k] - trial;
				root_s[k+1] <= root_s[k] | (33'd1 << B);
			end else begin
				rem_s[k+1]  <= rem_s[k];
				root_s[k+1] <= root_s[k];
			end
		end
	end

	// Stage 38: speed product and the reached test.
	logic [48:0] lin_prod_s38;
	logic        reached_s38;
	always_ff @(posedge clk) begin
		lin_prod_s38 <= lin_gain_q * root_s[SQRT_STEPS];
		reached_s38  <= root_s[SQRT_STEPS] < {1'b0, tol_q};
	end

	// Stage 2: quarter turn into the right half plane.
	logic signed [CW-1:0] cx_s [0:CORDIC_STEPS];
	logic signed [CW-1:0] cy_s [0:CORDIC_STEPS];
	logic signed [ZW-1:0] cz_s [0:CORDIC_STEPS];
	logic                 zero_s [0:CORDIC_STEPS];
	logic signed [14:0]   hd_s [0:CORDIC_STEPS];
	logic signed [CW-1:0] x0, y0;
	assign x0 = {{3{dx_s1[32]}}, dx_s1, 16'd0};
	assign y0 = {{3{dy_s1[32]}}, dy_s1, 16'd0};

	always_ff @(posedge clk) begin
		zero_s[0] <= (dx_s1 == '0) && (dy_s1 == '0);
		hd_s[0]   <= hd_s1;
		if (!dx_s1[32]) begin
			cx_s[0] <= x0;
			cy_s[0] <= y0;
			cz_s[0] <= '0;
		end else if (!dy_s1[32]) begin
			cx_s[0] <= y0;
			cy_s[0] <= -x0;
			cz_s[0] <= HALF_PI_Q16;
		end else begin
			cx_s[0] <= -y0;
			cy_s[0] <= x0;
			cz_s[0] <= -HALF_PI_Q16;
		end
	end

	// Stages 3 to 18: CORDIC vectoring, one rotation per stage.
	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
		logic signed [CW-1:0] xs, ys;
		assign xs = cx_s[i] >>> i;
		assign ys = cy_s[i] >>> i;
		always_ff @(posedge clk) begin
			zero_s[i+1] <= zero_s[i];
			hd_s[i+1]   <= hd_s[i];
			if (!cy_s[i][CW-1]) begin
				cx_s[i+1] <= cx_s[i] + ys;
				cy_s[i+1] <= cy_s[i] - xs;
				cz_s[i+1] <= cz_s[i] + atan_q16(i);
			end else begin
				cx_s[i+1] <= cx_s[i] - ys;
				cy_s[i+1] <= cy_s[i] + xs;
				cz_s[i+1] <= cz_s[i] - atan_q16(i);
			end
		end
	end

	// Stage 19: bearing in Q4.12 and the raw heading error.
	logic signed [ZW-1:0] z_round;
	logic signed [15:0]   bearing;
	logic signed [16:0]   err_s19;
	assign z_round = cz_s[CORDIC_STEPS] + 20'sd8;
	assign bearing = zero_s[CORDIC_STEPS] ? 16'sd0 : z_round[19:4];
	always_ff @(posedge clk) begin
		err_s19 <= 17'(bearing) - 17'(hd_s[CORDIC_STEPS]);
	end

	// Stage 20: wrap the error into plus or minus pi.
	logic signed [16:0] err_s20;
	always_ff @(posedge clk) begin
		priority if (err_s19 > PI_Q12) begin
			err_s20 <= err_s19 - TWO_PI_Q12;
		end else if (err_s19 < -PI_Q12) begin
			err_s20 <= err_s19 + TWO_PI_Q12;
		end else begin
			err_s20 <= err_s19;
		end
	end

	// Stage 21: angular gain product.
	logic signed [33:0] turn_prod_s21;
	always_ff @(posedge clk) begin
		turn_prod_s21 <= $signed({1'b0, ang_gain_q}) * err_s20;
	end

	// Stage 22: scale and saturate the turn rate.
	logic signed [17:0] turn_scaled;
	assign turn_scaled = turn_prod_s21[33:16];

	localparam int TR_DLY = 16;
	logic signed [15:0] tr_line [0:TR_DLY];
	always_ff @(posedge clk) begin
		priority if (turn_scaled > 18'sd32767) begin
			tr_line[0] <= 16'sh7FFF;
		end else if (turn_scaled < -18'sd32768) begin
			tr_line[0] <= 16'sh8000;
		end else begin
			tr_line[0] <= turn_scaled[15:0];
		end
	end

	// Stages 23 to 38: hold the turn rate until the distance is ready.
	for (genvar j = 0; j < TR_DLY; j++) begin : g_tr_dly
		always_ff @(posedge clk) begin
			tr_line[j+1] <= tr_line[j];
		end
	end

	// Stage 39: output register.
	logic [32:0] lin_scaled;
	assign lin_scaled = lin_prod_s38[48:16];
	always_ff @(posedge clk) begin
		reached <= reached_s38;
		if (reached_s38) begin
			linear_speed <= '0;
			turn_rate    <= '0;
		end else begin
			linear_speed <= (lin_scaled[32:31] != 2'b00) ? 31'h7FFF_FFFF : lin_scaled[30:0];
			turn_rate    <= tr_line[TR_DLY];
		end
	end

	assign strobe = vld[LAT];

endmodule
